/* src/bgc_pkg.sv */
// bgc_pkg: shared types and constants of the button gesture classifier
// no dependencies; imported by every module of the block
`default_nettype none

package bgc_pkg;

  localparam int TIME_W   = 48;
  localparam int SEC_W    = 29;
  localparam int CFG_W    = 24;
  localparam int SRT_W    = TIME_W + 1;
  localparam int IDX_W    = 3;
  localparam int CODE_W   = 3;
  localparam int MAX_EV   = 3;
  localparam int EV_CNT_W = 2;
  localparam int QDEPTH   = 2;

  // seconds divider: us / 1e6 = (us >> 6) / 15625
  // 2^21 = 134 * 15625 + 3402, so two folds at bit 21 leave a 24-bit rest
  // that a reciprocal multiply divides exactly
  localparam int US_SHIFT    = 6;
  localparam int SCALED_W    = TIME_W - US_SHIFT;
  localparam int FOLD_W      = 21;
  localparam int FOLD_HI_W   = SCALED_W - FOLD_W;
  localparam int FOLD1_W     = 33;
  localparam int FOLD2_HI_W  = FOLD1_W - FOLD_W;
  localparam int FOLD2_W     = 24;
  localparam int QHI_W       = FOLD_HI_W + 1;
  localparam int QA_W        = QHI_W + 8;
  localparam int RECIP_W     = 25;
  localparam int RECIP_SHIFT = 38;
  localparam int PROD_W      = FOLD2_W + RECIP_W;
  localparam int QLO_W       = PROD_W - RECIP_SHIFT;
  localparam logic [11:0]        FOLD_REM  = 12'd3402;
  localparam logic [7:0]         FOLD_MUL  = 8'd134;
  localparam logic [RECIP_W-1:0] SEC_RECIP = 25'd17592187;

  // register indexes
  localparam logic [IDX_W-1:0] REG_GAP_MIN    = 3'd0;
  localparam logic [IDX_W-1:0] REG_GAP_MAX    = 3'd1;
  localparam logic [IDX_W-1:0] REG_REPORT_MIN = 3'd2;
  localparam logic [IDX_W-1:0] REG_SHORT_WIN  = 3'd3;
  localparam logic [IDX_W-1:0] REG_BACKOFF    = 3'd4;

  localparam logic [CFG_W-1:0] RST_GAP_MIN    = 24'd80000;
  localparam logic [CFG_W-1:0] RST_GAP_MAX    = 24'd300000;
  localparam logic [CFG_W-1:0] RST_REPORT_MIN = 24'd300000;
  localparam logic [CFG_W-1:0] RST_SHORT_WIN  = 24'd280000;
  localparam logic [CFG_W-1:0] RST_BACKOFF    = 24'd150000;

  // event codes
  localparam logic [CODE_W-1:0] EV_HOLD    = 3'd0;
  localparam logic [CODE_W-1:0] EV_SECOND  = 3'd1;
  localparam logic [CODE_W-1:0] EV_WIN2_4  = 3'd2;
  localparam logic [CODE_W-1:0] EV_WIN6_10 = 3'd3;
  localparam logic [CODE_W-1:0] EV_WIN10_12 = 3'd4;
  localparam logic [CODE_W-1:0] EV_LONG    = 3'd5;
  localparam logic [CODE_W-1:0] EV_DOUBLE  = 3'd6;
  localparam logic [CODE_W-1:0] EV_SHORT   = 3'd7;

  // hold window bounds in whole seconds
  localparam logic [SEC_W-1:0] SEC_2  = 29'd2;
  localparam logic [SEC_W-1:0] SEC_4  = 29'd4;
  localparam logic [SEC_W-1:0] SEC_6  = 29'd6;
  localparam logic [SEC_W-1:0] SEC_10 = 29'd10;
  localparam logic [SEC_W-1:0] SEC_12 = 29'd12;

  typedef enum logic [1:0] {
    KIND_IDLE,
    KIND_PRESS,
    KIND_HOLD,
    KIND_RELEASE
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [TIME_W-1:0]  now_us;
    logic [TIME_W-1:0]  hold_us;
    logic [SEC_W-1:0]   hold_sec;
  } sample_t;

  typedef struct packed {
    logic [CFG_W-1:0] gap_min;
    logic [CFG_W-1:0] gap_max;
    logic [CFG_W-1:0] report_min;
    logic [CFG_W-1:0] short_win;
    logic [CFG_W-1:0] backoff;
  } cfg_t;

endpackage

`default_nettype wire

/* src/bgc_front.sv */
// bgc_front: accepts level samples, finds the edge kind and the raw hold time
// depends on bgc_pkg
`default_nettype none

module bgc_front import bgc_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              adv,
  input  wire logic              in_valid,
  input  wire logic              in_pin_level,
  input  wire logic [TIME_W-1:0] in_now_us,
  output      logic              o_valid,
  output      sample_t           o_sample
);

  logic              prev_level_r;
  logic [TIME_W-1:0] press_time_r;
  logic              v_r;
  sample_t           smp_r;
  kind_t             kind;
  logic              take;

  assign take = in_valid && adv;

  always_comb begin
    unique case ({prev_level_r, in_pin_level})
      2'b10:   kind = KIND_PRESS;
      2'b00:   kind = KIND_HOLD;
      2'b01:   kind = KIND_RELEASE;
      default: kind = KIND_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_level_r <= 1'b1;
      press_time_r <= '0;
      v_r          <= 1'b0;
    end else begin
      if (adv) v_r <= in_valid;
      if (take) begin
        prev_level_r <= in_pin_level;
        if (kind == KIND_PRESS) press_time_r <= in_now_us;
      end
    end
  end

  // hold time wraps modulo 2^48
  always_ff @(posedge clk) begin
    if (take) begin
      smp_r.kind     <= kind;
      smp_r.now_us   <= in_now_us;
      smp_r.hold_us  <= in_now_us - press_time_r;
      smp_r.hold_sec <= '0;
    end
  end

  assign o_valid  = v_r;
  assign o_sample = smp_r;

endmodule

`default_nettype wire

/* src/bgc_divsec.sv */
// bgc_divsec: four-stage constant divider giving whole seconds of hold time
// depends on bgc_pkg
`default_nettype none

module bgc_divsec import bgc_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    adv,
  input  wire logic    in_v,
  input  wire sample_t in_s,
  output      logic    out_v,
  output      sample_t out_s
);

  logic [SCALED_W-1:0]   scaled;
  logic [FOLD_HI_W-1:0]  xh;
  logic [FOLD_W-1:0]     xl;
  logic [FOLD1_W-1:0]    y_nxt;
  logic [FOLD2_HI_W-1:0] yh;
  logic [FOLD_W-1:0]     yl;
  logic [FOLD2_W-1:0]    z_nxt;
  logic [QHI_W-1:0]      qh_nxt;
  logic [QA_W-1:0]       qa_nxt;
  logic [QLO_W-1:0]      qlo_nxt;
  logic [SEC_W-1:0]      sec_nxt;

  logic                  s1_v_r, s2_v_r, s3_v_r, s4_v_r;
  sample_t               s1_s_r, s2_s_r, s3_s_r, s4_s_r;
  logic [FOLD_HI_W-1:0]  xh_r;
  logic [FOLD1_W-1:0]    y_r;
  logic [FOLD2_W-1:0]    z_r;
  logic [QHI_W-1:0]      qh_r;
  logic [QA_W-1:0]       qa_r;
  logic [QLO_W-1:0]      qlo_r;
  logic [SEC_W-1:0]      sec_r;

  // x = xh * 2^21 + xl folds to 134 * 15625 * xh + (3402 * xh + xl)
  assign scaled  = in_s.hold_us[TIME_W-1:US_SHIFT];
  assign xh      = scaled[SCALED_W-1:FOLD_W];
  assign xl      = scaled[FOLD_W-1:0];
  assign y_nxt   = FOLD1_W'(xh) * FOLD1_W'(FOLD_REM) + FOLD1_W'(xl);

  // second fold of the same kind leaves a rest below 2^24
  assign yh      = y_r[FOLD1_W-1:FOLD_W];
  assign yl      = y_r[FOLD_W-1:0];
  assign z_nxt   = FOLD2_W'(yh) * FOLD2_W'(FOLD_REM) + FOLD2_W'(yl);
  assign qh_nxt  = QHI_W'(xh_r) + QHI_W'(yh);

  // reciprocal multiply is exact for a rest below 2^24
  assign qlo_nxt = QLO_W'(PROD_W'(z_r) * PROD_W'(SEC_RECIP) >> RECIP_SHIFT);
  assign qa_nxt  = QA_W'(qh_r) * QA_W'(FOLD_MUL);

  assign sec_nxt = SEC_W'(qa_r + QA_W'(qlo_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_v;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_s_r <= in_s;
      xh_r   <= xh;
      y_r    <= y_nxt;
      s2_s_r <= s1_s_r;
      z_r    <= z_nxt;
      qh_r   <= qh_nxt;
      s3_s_r <= s2_s_r;
      qa_r   <= qa_nxt;
      qlo_r  <= qlo_nxt;
      s4_s_r <= s3_s_r;
      sec_r  <= sec_nxt;
    end
  end

  always_comb begin
    out_s          = s4_s_r;
    out_s.hold_sec = sec_r;
  end

  assign out_v = s4_v_r;

endmodule

`default_nettype wire

/* src/bgc_queue.sv */
// bgc_queue: short word queue between the front pipeline and the event sequencer
// depends on bgc_pkg
`default_nettype none

module bgc_queue import bgc_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push_valid,
  output      logic    push_ready,
  input  wire sample_t push_data,
  output      logic    pop_valid,
  input  wire logic    pop_ready,
  output      sample_t pop_data
);

  localparam int PTR_W = $clog2(QDEPTH);
  localparam int CNT_W = $clog2(QDEPTH + 1);

  sample_t           entry_r [QDEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              push;
  logic              pop;

  assign push_ready = cnt_r != CNT_W'(QDEPTH);
  assign pop_valid  = cnt_r != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= (rd_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) entry_r[wr_ptr_r] <= push_data;
  end

endmodule

`default_nettype wire

/* src/bgc_back.sv */
// bgc_back: gesture state and event sequencer; turns each sample into 0..3 events
// depends on bgc_pkg
`default_nettype none

module bgc_back import bgc_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cfg_t               cfg,
  input  wire logic               q_valid,
  output      logic               q_ready,
  input  wire sample_t            q_sample,
  output      logic               out_valid,
  input  wire logic               out_ready,
  output      logic [CODE_W-1:0]  out_event_code,
  output      logic [TIME_W-1:0]  out_held_us,
  output      logic [SEC_W-1:0]   out_held_sec,
  output      logic               out_in_window,
  output      logic               out_is_held,
  output      logic               out_last
);

  // gesture state
  logic              dbl_r, dbl_nxt;
  logic              holding_r, holding_nxt;
  logic              window_r, window_nxt;
  logic [TIME_W-1:0] hold_us_r, hold_us_nxt;
  logic [SEC_W-1:0]  hold_sec_r, hold_sec_nxt;
  logic [SRT_W-1:0]  srt_r, srt_nxt;

  // pending events of the current word
  logic [CODE_W-1:0]   pend_code_r [MAX_EV];
  logic                pend_win_r  [MAX_EV];
  logic [EV_CNT_W-1:0] left_r;
  logic [TIME_W-1:0]   ev_us_r;
  logic [SEC_W-1:0]    ev_sec_r;
  logic                ev_held_r;

  logic                cand_v    [MAX_EV];
  logic [CODE_W-1:0]   cand_code [MAX_EV];
  logic                cand_win  [MAX_EV];
  logic [CODE_W-1:0]   slot_code [MAX_EV];
  logic                slot_win  [MAX_EV];
  logic [EV_CNT_W-1:0] cnt;

  logic signed [TIME_W+1:0] diff;
  logic signed [TIME_W+1:0] lim_min;
  logic signed [TIME_W+1:0] lim_max;
  logic signed [TIME_W+1:0] lim_short;
  logic                     pop;
  logic                     shift;

  assign pop   = q_valid && (left_r == '0 || (left_r == EV_CNT_W'(1) && out_ready));
  assign shift = (left_r != '0) && out_ready;
  assign q_ready = pop;

  // signed gap from the last short release
  assign diff      = $signed({2'b00, q_sample.now_us}) - $signed({srt_r[SRT_W-1], srt_r});
  assign lim_min   = $signed({(TIME_W + 2 - CFG_W)'(0), cfg.gap_min});
  assign lim_max   = $signed({(TIME_W + 2 - CFG_W)'(0), cfg.gap_max});
  assign lim_short = $signed({(TIME_W + 2 - CFG_W)'(0), cfg.short_win});

  always_comb begin
    dbl_nxt      = dbl_r;
    holding_nxt  = holding_r;
    window_nxt   = window_r;
    hold_us_nxt  = hold_us_r;
    hold_sec_nxt = hold_sec_r;
    srt_nxt      = srt_r;
    for (int i = 0; i < MAX_EV; i++) begin
      cand_v[i]    = 1'b0;
      cand_code[i] = EV_HOLD;
      cand_win[i]  = 1'b0;
    end

    case (q_sample.kind)
      KIND_PRESS: begin
        dbl_nxt      = (diff > lim_min) && (diff < lim_max);
        holding_nxt  = !dbl_nxt;
        hold_us_nxt  = '0;
        hold_sec_nxt = '0;
        window_nxt   = 1'b0;
      end
      KIND_HOLD: begin
        if (!dbl_r && holding_r) begin
          hold_us_nxt  = q_sample.hold_us;
          hold_sec_nxt = q_sample.hold_sec;
          cand_v[0]    = (hold_us_r != q_sample.hold_us) &&
                         (q_sample.hold_us > TIME_W'(cfg.report_min));
          cand_code[0] = EV_HOLD;
          cand_win[0]  = window_r;
          cand_v[1]    = hold_sec_r != q_sample.hold_sec;
          cand_code[1] = EV_SECOND;
          cand_win[1]  = window_r;
          cand_win[2]  = 1'b1;
          window_nxt   = 1'b1;
          cand_v[2]    = 1'b1;
          if (q_sample.hold_sec >= SEC_2 && q_sample.hold_sec < SEC_4) begin
            cand_code[2] = EV_WIN2_4;
          end else if (q_sample.hold_sec >= SEC_6 && q_sample.hold_sec < SEC_10) begin
            cand_code[2] = EV_WIN6_10;
          end else if (q_sample.hold_sec >= SEC_10 && q_sample.hold_sec < SEC_12) begin
            cand_code[2] = EV_WIN10_12;
          end else begin
            cand_v[2]  = 1'b0;
            window_nxt = 1'b0;
          end
        end
      end
      KIND_RELEASE: begin
        holding_nxt  = 1'b0;
        window_nxt   = 1'b0;
        hold_us_nxt  = q_sample.hold_us;
        hold_sec_nxt = q_sample.hold_sec;
        if (dbl_r) begin
          cand_v[0]    = 1'b1;
          cand_code[0] = EV_DOUBLE;
        end else if (q_sample.hold_sec == '0) begin
          srt_nxt = {1'b0, q_sample.now_us};
        end else begin
          cand_v[0]    = 1'b1;
          cand_code[0] = EV_LONG;
        end
      end
      default: begin
        // released and idle: deferred short event
        if (!dbl_r && srt_r != '0 && diff < lim_short) begin
          cand_v[0]    = 1'b1;
          cand_code[0] = EV_SHORT;
          cand_win[0]  = window_r;
          srt_nxt      = srt_r - SRT_W'(cfg.backoff);
        end
      end
    endcase

    // pack the raised events in order
    cnt = '0;
    for (int i = 0; i < MAX_EV; i++) begin
      slot_code[i] = EV_HOLD;
      slot_win[i]  = 1'b0;
    end
    for (int i = 0; i < MAX_EV; i++) begin
      if (cand_v[i]) begin
        slot_code[cnt] = cand_code[i];
        slot_win[cnt]  = cand_win[i];
        cnt            = cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dbl_r      <= 1'b0;
      holding_r  <= 1'b0;
      window_r   <= 1'b0;
      hold_us_r  <= '0;
      hold_sec_r <= '0;
      srt_r      <= '0;
      left_r     <= '0;
    end else begin
      if (pop) begin
        dbl_r      <= dbl_nxt;
        holding_r  <= holding_nxt;
        window_r   <= window_nxt;
        hold_us_r  <= hold_us_nxt;
        hold_sec_r <= hold_sec_nxt;
        srt_r      <= srt_nxt;
        left_r     <= cnt;
      end else if (shift) begin
        left_r <= left_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      for (int i = 0; i < MAX_EV; i++) begin
        pend_code_r[i] <= slot_code[i];
        pend_win_r[i]  <= slot_win[i];
      end
      ev_us_r   <= hold_us_nxt;
      ev_sec_r  <= hold_sec_nxt;
      ev_held_r <= holding_nxt;
    end else if (shift) begin
      for (int i = 0; i < MAX_EV - 1; i++) begin
        pend_code_r[i] <= pend_code_r[i+1];
        pend_win_r[i]  <= pend_win_r[i+1];
      end
    end
  end

  assign out_valid      = left_r != '0;
  assign out_event_code = pend_code_r[0];
  assign out_in_window  = pend_win_r[0];
  assign out_held_us    = ev_us_r;
  assign out_held_sec   = ev_sec_r;
  assign out_is_held    = ev_held_r;
  assign out_last       = left_r == EV_CNT_W'(1);

endmodule

`default_nettype wire

/* src/button_gesture_classifier.sv */
// Button gesture classifier. A level sample (active-low pin plus microsecond
// timestamp) is taken on every clock while the front pipeline can move: one
// accept stage that finds press and release edges and the raw hold time, then
// a four-stage divider that turns microseconds into whole seconds (two folds
// by the constant divisor and a reciprocal multiply). A two-word queue feeds
// the event sequencer, which offers a sample's n events (n is 0 to 3) one at
// a time on the single result port. A sample passes the accept, divider and
// queue registers before its first event is offered. Events carry the code
// (hold, per second, hold windows 2-4 s, 6-10 s and 10-12 s, long, double,
// short), the hold time, whether a window is active and whether a single
// press is held; last marks the final event of a sample. Configuration writes
// are always taken; unknown indexes are ignored.
// depends on bgc_pkg, bgc_front, bgc_divsec, bgc_queue, bgc_back
`default_nettype none

module button_gesture_classifier import bgc_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output      logic              in_ready,
  input  wire logic              in_pin_level,
  input  wire logic [TIME_W-1:0] in_now_us,
  output      logic              out_valid,
  input  wire logic              out_ready,
  output      logic [CODE_W-1:0] out_event_code,
  output      logic [TIME_W-1:0] out_held_us,
  output      logic [SEC_W-1:0]  out_held_sec,
  output      logic              out_in_window,
  output      logic              out_is_held,
  output      logic              out_last,
  input  wire logic              cfg_valid,
  output      logic              cfg_ready,
  input  wire logic [IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_data
);

  cfg_t    cfg_r;
  logic    adv;
  logic    fr_valid;
  sample_t fr_sample;
  logic    dv_valid;
  sample_t dv_sample;
  logic    q_push_ready;
  logic    q_valid;
  logic    q_ready;
  sample_t q_sample;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gap_min    <= RST_GAP_MIN;
      cfg_r.gap_max    <= RST_GAP_MAX;
      cfg_r.report_min <= RST_REPORT_MIN;
      cfg_r.short_win  <= RST_SHORT_WIN;
      cfg_r.backoff    <= RST_BACKOFF;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_GAP_MIN:    cfg_r.gap_min    <= cfg_data;
        REG_GAP_MAX:    cfg_r.gap_max    <= cfg_data;
        REG_REPORT_MIN: cfg_r.report_min <= cfg_data;
        REG_SHORT_WIN:  cfg_r.short_win  <= cfg_data;
        REG_BACKOFF:    cfg_r.backoff    <= cfg_data;
        default: ;
      endcase
    end
  end

  // whole front pipeline stalls only when its last word cannot enter the queue
  assign adv      = !dv_valid || q_push_ready;
  assign in_ready = adv;

  bgc_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .adv          (adv),
    .in_valid     (in_valid),
    .in_pin_level (in_pin_level),
    .in_now_us    (in_now_us),
    .o_valid      (fr_valid),
    .o_sample     (fr_sample)
  );

  bgc_divsec u_divsec (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .in_v  (fr_valid),
    .in_s  (fr_sample),
    .out_v (dv_valid),
    .out_s (dv_sample)
  );

  bgc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (dv_valid),
    .push_ready (q_push_ready),
    .push_data  (dv_sample),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_sample)
  );

  bgc_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .q_valid        (q_valid),
    .q_ready        (q_ready),
    .q_sample       (q_sample),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_event_code (out_event_code),
    .out_held_us    (out_held_us),
    .out_held_sec   (out_held_sec),
    .out_in_window  (out_in_window),
    .out_is_held    (out_is_held),
    .out_last       (out_last)
  );

endmodule

`default_nettype wire
